### rtl/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg: shared types and constants for the keyed record table
// Operation codes, status codes, beat structs and the per-cell control bundle.
// ----------------------------------------------------------------------------
package krt_pkg;

    localparam int KRT_CAPACITY = 64;
    localparam int KEY_W        = 64;
    localparam int PRIO_W       = 3;
    localparam int DEST_W       = 16;
    localparam int COUNT_OUT_W  = 7;

    typedef enum logic [1:0]
    {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2,
        OP_UPDATE = 2'd3
    } krt_op_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef enum logic
    {
        KRT_IDLE  = 1'b0,
        KRT_APPLY = 1'b1
    } krt_state_t;

    typedef struct packed
    {
        krt_op_t             operation;
        logic [KEY_W-1:0]    record_key;
        logic [PRIO_W-1:0]   record_priority;
        logic [DEST_W-1:0]   record_destination;
    } krt_in_t;

    typedef struct packed
    {
        logic [1:0]             status;
        logic [PRIO_W-1:0]      found_priority;
        logic [DEST_W-1:0]      found_destination;
        logic [COUNT_OUT_W-1:0] entry_count;
    } krt_out_t;

    typedef struct packed
    {
        logic [KEY_W-1:0]  key;
        logic [PRIO_W-1:0] prio;
        logic [DEST_W-1:0] dest;
    } krt_rec_t;

    // per-cell control, one bundle per slot
    typedef struct packed
    {
        logic capture;   // latch key compare result
        logic live;      // slot lies below the fill count
        logic load_new;  // insert lands here
        logic load_upd;  // update rewrites priority and destination
        logic shift;     // take the record of the upper neighbour
    } krt_cell_ctrl_t;

endpackage

### rtl/keyed_record_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_record_table_unit: packed table of keyed records in a row of cells
// Insert, search, remove with compaction and update, one result per command.
// ----------------------------------------------------------------------------
// usage
//   in channel : one command beat (operation, key, priority, destination),
//                taken when in_valid and in_ready are both high
//   out channel: one result beat (status, found priority and destination,
//                entry count after the command) per command
//   timing     : every cell compares its key with the incoming key on the
//                accepting edge; on the next edge the lowest hit is picked
//                out (one wide subtract over the hit vector), the cells
//                shift, load or rewrite, and the result beat is registered.
//                out_valid rises on that same edge, and no new command is
//                taken before the result beat of the last one is registered
//   reset      : rst_n clears the fill count, the control state and the
//                output valid; slot contents are left as they are and are
//                never read before written
//   stalls     : a result beat waits in the output register; the next
//                command is taken only when that register is empty or is
//                being emptied on the same edge
// ----------------------------------------------------------------------------
module keyed_record_table_unit
#(
    parameter int CAPACITY = krt_pkg::KRT_CAPACITY
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  krt_pkg::krt_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output krt_pkg::krt_out_t out_data
);
    import krt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    // control state
    krt_state_t state_reg;
    krt_state_t state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    // payload state
    krt_in_t  cmd_reg;
    krt_in_t  cmd_next;
    krt_out_t out_reg;
    krt_out_t out_next;

    // cell row
    krt_rec_t       rec_row [CAPACITY];
    krt_cell_ctrl_t ctrl_row [CAPACITY];
    logic [CAPACITY-1:0] hit_vec;
    logic [CAPACITY-1:0] hit_dec;
    logic [CAPACITY-1:0] first_hot;
    logic [CAPACITY-1:0] below_hit;
    logic                found;
    logic                full;
    logic                accept;
    krt_rec_t            new_rec;
    logic [PRIO_W-1:0]   rd_prio;
    logic [DEST_W-1:0]   rd_dest;
    logic [CW+COUNT_OUT_W-1:0] count_ext;

    assign in_ready  = (state_reg == KRT_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign new_rec.key  = cmd_reg.record_key;
    assign new_rec.prio = cmd_reg.record_priority;
    assign new_rec.dest = cmd_reg.record_destination;

    // lowest hit: m - 1 clears the lowest set bit and sets everything below
    assign hit_dec   = hit_vec - {{(CAPACITY-1){1'b0}}, 1'b1};
    assign first_hot = hit_vec & ~hit_dec;
    assign below_hit = ~hit_vec & hit_dec;
    assign found     = |hit_vec;
    assign full      = (count_reg == CW'(CAPACITY));

    // per-slot control
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            ctrl_row[i].capture  = accept;
            ctrl_row[i].live     = (CW'(i) < count_reg);
            ctrl_row[i].load_new = (state_reg == KRT_APPLY) && (cmd_reg.operation == OP_INSERT)
                                   && !full && (count_reg == CW'(i));
            ctrl_row[i].load_upd = (state_reg == KRT_APPLY) && (cmd_reg.operation == OP_UPDATE)
                                   && first_hot[i];
            ctrl_row[i].shift    = (state_reg == KRT_APPLY) && (cmd_reg.operation == OP_REMOVE)
                                   && found && !below_hit[i];
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            krt_rec_t upper;
            if (g == CAPACITY - 1)
            begin : g_top
                assign upper = rec_row[g];
            end
            else
            begin : g_mid
                assign upper = rec_row[g+1];
            end

            krt_cell u_cell
            (
                .clk       (clk),
                .ctrl      (ctrl_row[g]),
                .cmp_key   (in_data.record_key),
                .new_rec   (new_rec),
                .upper_rec (upper),
                .rec       (rec_row[g]),
                .hit       (hit_vec[g])
            );
        end
    endgenerate

    // read-out of the matched slot, first_hot is one-hot or empty
    always_comb
    begin
        rd_prio = '0;
        rd_dest = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_prio = rd_prio | (rec_row[i].prio & {PRIO_W{first_hot[i]}});
            rd_dest = rd_dest | (rec_row[i].dest & {DEST_W{first_hot[i]}});
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cmd_next       = cmd_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        count_ext      = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            KRT_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = in_data;
                    state_next = KRT_APPLY;
                end
            end
            KRT_APPLY:
            begin
                out_next.status            = ST_OK;
                out_next.found_priority    = '0;
                out_next.found_destination = '0;
                case (cmd_reg.operation)
                    OP_INSERT:
                    begin
                        if (full)
                        begin
                            out_next.status = ST_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_SEARCH:
                    begin
                        if (!found)
                        begin
                            out_next.status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            out_next.found_priority    = rd_prio;
                            out_next.found_destination = rd_dest;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!found)
                        begin
                            out_next.status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    OP_UPDATE:
                    begin
                        if (!found)
                        begin
                            out_next.status = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        out_next.status = ST_OK;
                    end
                endcase
                count_ext            = {{COUNT_OUT_W{1'b0}}, count_next};
                out_next.entry_count = count_ext[COUNT_OUT_W-1:0];
                out_valid_next       = 1'b1;
                state_next           = KRT_IDLE;
            end
            default:
            begin
                state_next = KRT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= KRT_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

endmodule

### rtl/krt_cell.sv
// ----------------------------------------------------------------------------
// krt_cell: one slot of the keyed record table
// Holds one record and a registered key hit, shifts down from its neighbour.
// ----------------------------------------------------------------------------
module krt_cell
(
    input  logic                   clk,
    input  krt_pkg::krt_cell_ctrl_t ctrl,
    input  logic [krt_pkg::KEY_W-1:0] cmp_key,
    input  krt_pkg::krt_rec_t      new_rec,
    input  krt_pkg::krt_rec_t      upper_rec,
    output krt_pkg::krt_rec_t      rec,
    output logic                   hit
);
    import krt_pkg::*;

    krt_rec_t rec_reg;
    krt_rec_t rec_next;
    logic     hit_reg;
    logic     hit_next;

    always_comb
    begin
        rec_next = rec_reg;
        if (ctrl.shift)
        begin
            rec_next = upper_rec;
        end
        else if (ctrl.load_new)
        begin
            rec_next = new_rec;
        end
        else if (ctrl.load_upd)
        begin
            rec_next.prio = new_rec.prio;
            rec_next.dest = new_rec.dest;
        end
    end

    assign hit_next = ctrl.capture ? (ctrl.live && (rec_reg.key == cmp_key)) : hit_reg;

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        hit_reg <= hit_next;
    end

    assign rec = rec_reg;
    assign hit = hit_reg;

endmodule
